@@ src/tsos_pkg.sv @@
// ---------------------------------------------------------------------------
// tsos_pkg
// shared types and constants of the time series outlier screen
// ---------------------------------------------------------------------------
package tsos_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DAY_W     = 16;
    localparam int THR_W     = 16;
    localparam int RESID_W   = 24;
    localparam int SUM_W     = 64;
    localparam int IDX_MAX_W = 6;   // index field wide enough for the largest series
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ABOVE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BELOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] NODATA_RESET = -16'sd9999;

    // one stored date, travelling from the front to the back
    typedef struct packed {
        logic [IDX_MAX_W-1:0]       idx;
        logic                       fin;
        logic                       ok;
        logic [DAY_W-1:0]           day;
        logic signed [SAMPLE_W-1:0] sample;
    } entry_t;

    typedef enum logic [4:0] {
        B_IDLE,
        B_PASS_INIT,
        B_SCAN,
        B_LOAD,
        B_RES_WAIT,
        B_ACCUM,
        B_PASS_END,
        B_NOISE_LHS,
        B_MUL_RUN,
        B_RM_DECIDE,
        B_RST_INIT,
        B_RST_START,
        B_RST_SCAN,
        B_RST_LOAD_L,
        B_RST_LOAD_M,
        B_RSR_SCAN,
        B_RSR_LOAD,
        B_RST_RES_WAIT,
        B_RST_LHS,
        B_RST_DECIDE,
        B_EMIT
    } back_state_t;

    typedef enum logic [2:0] {
        R_IDLE,
        R_DIV,
        R_SLOPE,
        R_MUL,
        R_FIN
    } resid_state_t;

endpackage

@@ src/tsos_front.sv @@
// ---------------------------------------------------------------------------
// tsos_front
// accepts dates, numbers them and marks the date that closes a series
// ---------------------------------------------------------------------------
module tsos_front #(
    parameter int MAX_DATES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 push,
    output tsos_pkg::entry_t     push_data
);

    localparam int CNT_W = $clog2(MAX_DATES + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             fin;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;
    // store full closes the series as if tlast were set
    assign fin      = s_tlast || (cnt_reg == CNT_W'(MAX_DATES - 1));

    always_comb
    begin
        push_data.sample = s_tdata[15:0];
        push_data.day    = s_tdata[31:16];
        push_data.ok     = s_tdata[32];
        push_data.fin    = fin;
        push_data.idx    = tsos_pkg::IDX_MAX_W'(cnt_reg);
        cnt_next         = cnt_reg;
        if (push)
        begin
            cnt_next = fin ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ src/tsos_queue.sv @@
// ---------------------------------------------------------------------------
// tsos_queue
// two-entry queue between the front and the back
// ---------------------------------------------------------------------------
module tsos_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tsos_pkg::entry_t push_data,
    input  logic             pop,
    output tsos_pkg::entry_t pop_data,
    output logic             full,
    output logic             empty
);

    tsos_pkg::entry_t ent_reg [2];
    logic             wp_reg;
    logic             rp_reg;
    logic [1:0]       cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = ent_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ src/tsos_resid.sv @@
// ---------------------------------------------------------------------------
// tsos_resid
// absolute residual of a date against integer interpolation of its neighbours
// ---------------------------------------------------------------------------
module tsos_resid (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [15:0]    l_s,
    input  logic [15:0]           l_d,
    input  logic signed [15:0]    m_s,
    input  logic [15:0]           m_d,
    input  logic signed [15:0]    r_s,
    input  logic [15:0]           r_d,
    output logic                  done,
    output logic [23:0]           y
);

    tsos_pkg::resid_state_t state_reg, state_next;

    logic signed [16:0] num, span, dm, base;
    logic [16:0]        num_mag, span_mag;
    logic               neg_reg, neg_next;
    logic [16:0]        dvs_reg, dvs_next;
    logic [16:0]        q_reg, q_next;
    logic [16:0]        rem_reg, rem_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [16:0] dm_reg, dm_next;
    logic signed [16:0] base_reg, base_next;
    logic signed [17:0] slope_reg, slope_next;
    logic signed [34:0] prod_reg, prod_next;
    logic [23:0]        y_reg, y_next;
    logic               done_reg, done_next;
    logic [17:0]        sh;
    logic               ge;
    logic signed [35:0] e;
    logic [35:0]        e_mag;

    assign done = done_reg;
    assign y    = y_reg;

    always_comb
    begin
        num      = 17'(r_s) - 17'(l_s);
        span     = $signed({1'b0, r_d}) - $signed({1'b0, l_d});
        dm       = $signed({1'b0, m_d}) - $signed({1'b0, l_d});
        base     = 17'(m_s) - 17'(l_s);
        num_mag  = num[16] ? 17'(-num) : 17'(num);
        span_mag = span[16] ? 17'(-span) : 17'(span);
        sh       = {rem_reg, q_reg[16]};
        ge       = sh >= {1'b0, dvs_reg};
        e        = {{19{base_reg[16]}}, base_reg} - {prod_reg[34], prod_reg};
        e_mag    = e[35] ? 36'(-e) : 36'(e);

        state_next = state_reg;
        neg_next   = neg_reg;
        dvs_next   = dvs_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        dm_next    = dm_reg;
        base_next  = base_reg;
        slope_next = slope_reg;
        prod_next  = prod_reg;
        y_next     = y_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            tsos_pkg::R_IDLE:
            begin
                if (start)
                begin
                    neg_next  = num[16] ^ span[16];
                    dvs_next  = span_mag;
                    q_next    = num_mag;
                    rem_next  = '0;
                    cnt_next  = 5'd16;
                    dm_next   = dm;
                    base_next = base;
                    // zero day span gives slope zero
                    if (span == '0)
                    begin
                        q_next     = '0;
                        state_next = tsos_pkg::R_SLOPE;
                    end
                    else
                    begin
                        state_next = tsos_pkg::R_DIV;
                    end
                end
            end
            tsos_pkg::R_DIV:
            begin
                rem_next = ge ? 17'(sh - {1'b0, dvs_reg}) : sh[16:0];
                q_next   = {q_reg[15:0], ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = tsos_pkg::R_SLOPE;
                end
            end
            tsos_pkg::R_SLOPE:
            begin
                slope_next = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
                state_next = tsos_pkg::R_MUL;
            end
            tsos_pkg::R_MUL:
            begin
                prod_next  = 35'(slope_reg * dm_reg);
                state_next = tsos_pkg::R_FIN;
            end
            tsos_pkg::R_FIN:
            begin
                y_next     = (|e_mag[35:24]) ? 24'hFFFFFF : e_mag[23:0];
                done_next  = 1'b1;
                state_next = tsos_pkg::R_IDLE;
            end
            default:
            begin
                state_next = tsos_pkg::R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        dvs_reg   <= dvs_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        dm_reg    <= dm_next;
        base_reg  <= base_next;
        slope_reg <= slope_next;
        prod_reg  <= prod_next;
        y_reg     <= y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsos_pkg::R_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

@@ src/tsos_back.sv @@
// ---------------------------------------------------------------------------
// tsos_back
// stores a series, runs removal and restore passes and sends the results
// ---------------------------------------------------------------------------
module tsos_back #(
    parameter int MAX_DATES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tsos_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                        cfg_data,
    input  logic                               q_empty,
    input  tsos_pkg::entry_t                   q_data,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,
    output logic                               m_tlast
);

    localparam int IDX_W = $clog2(MAX_DATES);
    localparam int CNT_W = $clog2(MAX_DATES + 1);

    // configuration
    logic [15:0]        above_reg;
    logic [15:0]        below_reg;
    logic signed [15:0] nodata_reg;

    // sample and day store, read data registered
    logic [31:0]      mem [MAX_DATES];
    logic [31:0]      rd_reg;
    logic [IDX_W-1:0] raddr;
    logic             mem_we;

    tsos_pkg::back_state_t state_reg, state_next;

    logic [MAX_DATES-1:0] valid_reg, valid_next;
    logic [MAX_DATES-1:0] marks_reg, marks_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] t_reg, t_next;
    logic [CNT_W-1:0] u_reg, u_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             ran_reg, ran_next;
    logic             have_l_reg, have_l_next, have_m_reg, have_m_next;
    logic [IDX_W-1:0] l_idx_reg, l_idx_next, m_idx_reg, m_idx_next, r_idx_reg, r_idx_next;
    logic signed [15:0] l_s_reg, l_s_next, m_s_reg, m_s_next, r_s_reg, r_s_next;
    logic [15:0]      l_d_reg, l_d_next, m_d_reg, m_d_next, r_d_reg, r_d_next;
    logic [IDX_W-1:0] first_reg, first_next;
    logic             first_seen_reg, first_seen_next;
    logic [63:0]      sum_reg, sum_next;
    logic [23:0]      maxr_reg, maxr_next;
    logic [IDX_W-1:0] worst_reg, worst_next;
    logic [CNT_W-1:0] nres_reg, nres_next;
    logic [63:0]      nsum_reg, nsum_next;
    logic [CNT_W-1:0] ncnt_reg, ncnt_next;
    logic             known_reg, known_next;
    logic             rphase_reg, rphase_next;
    logic [47:0]      ysq_reg, ysq_next;
    logic [95:0]      lhs_reg, lhs_next;
    logic [95:0]      mcand_reg, mcand_next;
    logic [31:0]      mbits_reg, mbits_next;
    logic [95:0]      acc_reg, acc_next;
    logic [4:0]       mcnt_reg, mcnt_next;
    logic             ov_reg, ov_next;
    logic [2:0]       obits_reg, obits_next;
    logic             olast_reg, olast_next;

    // residual unit
    logic        res_start;
    logic        res_done;
    logic [23:0] res_y;

    logic [16:0] lr_abs, mr_abs, ml_abs;
    logic [IDX_W-1:0] blame;
    logic [IDX_W-1:0] t_idx;

    assign t_idx    = t_reg[IDX_W-1:0];
    assign m_tvalid = ov_reg;
    assign m_tdata  = {5'b0, obits_reg};
    assign m_tlast  = olast_reg;
    assign pop      = (state_reg == tsos_pkg::B_IDLE) && !q_empty;
    assign mem_we   = pop;
    assign raddr    = (state_reg == tsos_pkg::B_RSR_SCAN) ? u_reg[IDX_W-1:0] : t_idx;
    assign res_start = ((state_reg == tsos_pkg::B_LOAD) && have_l_reg && have_m_reg)
                       || (state_reg == tsos_pkg::B_RSR_LOAD);

    tsos_resid u_resid (
        .clk   (clk),
        .rst_n (rst_n),
        .start (res_start),
        .l_s   (l_s_reg),
        .l_d   (l_d_reg),
        .m_s   (m_s_reg),
        .m_d   (m_d_reg),
        .r_s   (rd_reg[15:0]),
        .r_d   (rd_reg[31:16]),
        .done  (res_done),
        .y     (res_y)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_data.idx[IDX_W-1:0]] <= {q_data.day, q_data.sample};
        end
        rd_reg <= mem[raddr];
    end

    always_comb
    begin
        lr_abs = (17'(l_s_reg) > 17'(r_s_reg)) ? 17'(l_s_reg - r_s_reg) : 17'(r_s_reg - l_s_reg);
        lr_abs = l_s_reg > r_s_reg ? 17'(17'(l_s_reg) - 17'(r_s_reg))
                                   : 17'(17'(r_s_reg) - 17'(l_s_reg));
        mr_abs = m_s_reg > r_s_reg ? 17'(17'(m_s_reg) - 17'(r_s_reg))
                                   : 17'(17'(r_s_reg) - 17'(m_s_reg));
        ml_abs = m_s_reg > l_s_reg ? 17'(17'(m_s_reg) - 17'(l_s_reg))
                                   : 17'(17'(l_s_reg) - 17'(m_s_reg));
        priority if ((l_idx_reg == first_reg) && (lr_abs > mr_abs))
        begin
            blame = l_idx_reg;
        end
        else if (lr_abs > ml_abs)
        begin
            blame = r_idx_reg;
        end
        else
        begin
            blame = m_idx_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        marks_next      = marks_reg;
        n_next          = n_reg;
        t_next          = t_reg;
        u_next          = u_reg;
        k_next          = k_reg;
        ran_next        = ran_reg;
        have_l_next     = have_l_reg;
        have_m_next     = have_m_reg;
        l_idx_next      = l_idx_reg;
        m_idx_next      = m_idx_reg;
        r_idx_next      = r_idx_reg;
        l_s_next        = l_s_reg;
        m_s_next        = m_s_reg;
        r_s_next        = r_s_reg;
        l_d_next        = l_d_reg;
        m_d_next        = m_d_reg;
        r_d_next        = r_d_reg;
        first_next      = first_reg;
        first_seen_next = first_seen_reg;
        sum_next        = sum_reg;
        maxr_next       = maxr_reg;
        worst_next      = worst_reg;
        nres_next       = nres_reg;
        nsum_next       = nsum_reg;
        ncnt_next       = ncnt_reg;
        known_next      = known_reg;
        rphase_next     = rphase_reg;
        ysq_next        = ysq_reg;
        lhs_next        = lhs_reg;
        mcand_next      = mcand_reg;
        mbits_next      = mbits_reg;
        acc_next        = acc_reg;
        mcnt_next       = mcnt_reg;
        ov_next         = ov_reg && !m_tready;
        obits_next      = obits_reg;
        olast_next      = olast_reg;

        unique case (state_reg)
            tsos_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    valid_next[q_data.idx[IDX_W-1:0]] = q_data.ok;
                    if (q_data.fin)
                    begin
                        n_next     = CNT_W'(q_data.idx) + CNT_W'(1);
                        marks_next = '0;
                        known_next = 1'b0;
                        k_next     = '0;
                        if (((above_reg == '0) && (below_reg == '0))
                            || (CNT_W'(q_data.idx) < CNT_W'(2)))
                        begin
                            ran_next   = 1'b0;
                            state_next = tsos_pkg::B_EMIT;
                        end
                        else
                        begin
                            ran_next   = 1'b1;
                            state_next = tsos_pkg::B_PASS_INIT;
                        end
                    end
                end
            end
            tsos_pkg::B_PASS_INIT:
            begin
                t_next          = '0;
                have_l_next     = 1'b0;
                have_m_next     = 1'b0;
                first_seen_next = 1'b0;
                sum_next        = '0;
                maxr_next       = '0;
                worst_next      = '0;
                nres_next       = '0;
                state_next      = tsos_pkg::B_SCAN;
            end
            tsos_pkg::B_SCAN:
            begin
                if (t_reg >= n_reg)
                begin
                    state_next = tsos_pkg::B_PASS_END;
                end
                else if (valid_reg[t_idx])
                begin
                    state_next = tsos_pkg::B_LOAD;
                end
                else
                begin
                    t_next = t_reg + CNT_W'(1);
                end
            end
            tsos_pkg::B_LOAD:
            begin
                if (!first_seen_reg)
                begin
                    first_next      = t_idx;
                    first_seen_next = 1'b1;
                end
                if (have_l_reg && have_m_reg)
                begin
                    r_idx_next = t_idx;
                    r_s_next   = rd_reg[15:0];
                    r_d_next   = rd_reg[31:16];
                    state_next = tsos_pkg::B_RES_WAIT;
                end
                else
                begin
                    l_idx_next  = m_idx_reg;
                    l_s_next    = m_s_reg;
                    l_d_next    = m_d_reg;
                    have_l_next = have_m_reg;
                    m_idx_next  = t_idx;
                    m_s_next    = rd_reg[15:0];
                    m_d_next    = rd_reg[31:16];
                    have_m_next = 1'b1;
                    t_next      = t_reg + CNT_W'(1);
                    state_next  = tsos_pkg::B_SCAN;
                end
            end
            tsos_pkg::B_RES_WAIT:
            begin
                if (res_done)
                begin
                    ysq_next = 48'(res_y * res_y);
                    // first largest residual wins
                    if (res_y > maxr_reg)
                    begin
                        maxr_next  = res_y;
                        worst_next = blame;
                    end
                    state_next = tsos_pkg::B_ACCUM;
                end
            end
            tsos_pkg::B_ACCUM:
            begin
                sum_next   = sum_reg + 64'(ysq_reg);
                nres_next  = nres_reg + CNT_W'(1);
                l_idx_next = m_idx_reg;
                l_s_next   = m_s_reg;
                l_d_next   = m_d_reg;
                m_idx_next = r_idx_reg;
                m_s_next   = r_s_reg;
                m_d_next   = r_d_reg;
                t_next     = t_reg + CNT_W'(1);
                state_next = tsos_pkg::B_SCAN;
            end
            tsos_pkg::B_PASS_END:
            begin
                if (nres_reg < CNT_W'(2))
                begin
                    state_next = known_reg ? tsos_pkg::B_RST_INIT : tsos_pkg::B_EMIT;
                end
                else
                begin
                    nsum_next  = sum_reg;
                    ncnt_next  = nres_reg;
                    known_next = 1'b1;
                    ysq_next   = 48'(maxr_reg * maxr_reg);
                    state_next = tsos_pkg::B_NOISE_LHS;
                end
            end
            tsos_pkg::B_NOISE_LHS:
            begin
                lhs_next    = 96'({55'(ysq_reg * ncnt_reg), 16'b0});
                mcand_next  = 96'(nsum_reg);
                mbits_next  = 32'(above_reg * above_reg);
                acc_next    = '0;
                mcnt_next   = 5'd31;
                rphase_next = 1'b0;
                state_next  = tsos_pkg::B_MUL_RUN;
            end
            tsos_pkg::B_MUL_RUN:
            begin
                if (mbits_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[94:0], 1'b0};
                mbits_next = {1'b0, mbits_reg[31:1]};
                mcnt_next  = mcnt_reg - 5'd1;
                if (mcnt_reg == '0)
                begin
                    state_next = rphase_reg ? tsos_pkg::B_RST_START : tsos_pkg::B_RM_DECIDE;
                end
            end
            tsos_pkg::B_RM_DECIDE:
            begin
                state_next = tsos_pkg::B_RST_INIT;
                if (lhs_reg > acc_reg)
                begin
                    valid_next[worst_reg] = 1'b0;
                    marks_next[worst_reg] = 1'b1;
                    if (nres_reg > CNT_W'(2))
                    begin
                        state_next = tsos_pkg::B_PASS_INIT;
                    end
                end
            end
            tsos_pkg::B_RST_INIT:
            begin
                mcand_next  = 96'(nsum_reg);
                mbits_next  = 32'(below_reg * below_reg);
                acc_next    = '0;
                mcnt_next   = 5'd31;
                rphase_next = 1'b1;
                state_next  = tsos_pkg::B_MUL_RUN;
            end
            tsos_pkg::B_RST_START:
            begin
                t_next      = '0;
                have_l_next = 1'b0;
                state_next  = tsos_pkg::B_RST_SCAN;
            end
            tsos_pkg::B_RST_SCAN:
            begin
                if (t_reg + CNT_W'(1) >= n_reg)
                begin
                    k_next     = '0;
                    state_next = tsos_pkg::B_EMIT;
                end
                else if (valid_reg[t_idx])
                begin
                    state_next = tsos_pkg::B_RST_LOAD_L;
                end
                else if (!marks_reg[t_idx] && have_l_reg)
                begin
                    state_next = tsos_pkg::B_RST_LOAD_M;
                end
                else
                begin
                    t_next = t_reg + CNT_W'(1);
                end
            end
            tsos_pkg::B_RST_LOAD_L:
            begin
                l_s_next    = rd_reg[15:0];
                l_d_next    = rd_reg[31:16];
                have_l_next = 1'b1;
                t_next      = t_reg + CNT_W'(1);
                state_next  = tsos_pkg::B_RST_SCAN;
            end
            tsos_pkg::B_RST_LOAD_M:
            begin
                m_s_next = rd_reg[15:0];
                m_d_next = rd_reg[31:16];
                // missing data is never restored
                if ($signed(rd_reg[15:0]) == nodata_reg)
                begin
                    t_next     = t_reg + CNT_W'(1);
                    state_next = tsos_pkg::B_RST_SCAN;
                end
                else
                begin
                    u_next     = t_reg + CNT_W'(1);
                    state_next = tsos_pkg::B_RSR_SCAN;
                end
            end
            tsos_pkg::B_RSR_SCAN:
            begin
                if (u_reg >= n_reg)
                begin
                    t_next     = t_reg + CNT_W'(1);
                    state_next = tsos_pkg::B_RST_SCAN;
                end
                else if (valid_reg[u_reg[IDX_W-1:0]])
                begin
                    state_next = tsos_pkg::B_RSR_LOAD;
                end
                else
                begin
                    u_next = u_reg + CNT_W'(1);
                end
            end
            tsos_pkg::B_RSR_LOAD:
            begin
                state_next = tsos_pkg::B_RST_RES_WAIT;
            end
            tsos_pkg::B_RST_RES_WAIT:
            begin
                if (res_done)
                begin
                    ysq_next   = 48'(res_y * res_y);
                    state_next = tsos_pkg::B_RST_LHS;
                end
            end
            tsos_pkg::B_RST_LHS:
            begin
                lhs_next   = 96'({55'(ysq_reg * ncnt_reg), 16'b0});
                state_next = tsos_pkg::B_RST_DECIDE;
            end
            tsos_pkg::B_RST_DECIDE:
            begin
                if (lhs_reg < acc_reg)
                begin
                    valid_next[t_idx] = 1'b1;
                    l_s_next          = m_s_reg;
                    l_d_next          = m_d_reg;
                    have_l_next       = 1'b1;
                end
                t_next     = t_reg + CNT_W'(1);
                state_next = tsos_pkg::B_RST_SCAN;
            end
            tsos_pkg::B_EMIT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    obits_next = {ran_reg, marks_reg[k_reg[IDX_W-1:0]],
                                  valid_reg[k_reg[IDX_W-1:0]]};
                    olast_next = (k_reg + CNT_W'(1) == n_reg);
                    k_next     = k_reg + CNT_W'(1);
                    if (k_reg + CNT_W'(1) == n_reg)
                    begin
                        state_next = tsos_pkg::B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = tsos_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        valid_reg      <= valid_next;
        n_reg          <= n_next;
        t_reg          <= t_next;
        u_reg          <= u_next;
        k_reg          <= k_next;
        ran_reg        <= ran_next;
        have_l_reg     <= have_l_next;
        have_m_reg     <= have_m_next;
        l_idx_reg      <= l_idx_next;
        m_idx_reg      <= m_idx_next;
        r_idx_reg      <= r_idx_next;
        l_s_reg        <= l_s_next;
        m_s_reg        <= m_s_next;
        r_s_reg        <= r_s_next;
        l_d_reg        <= l_d_next;
        m_d_reg        <= m_d_next;
        r_d_reg        <= r_d_next;
        first_reg      <= first_next;
        first_seen_reg <= first_seen_next;
        sum_reg        <= sum_next;
        maxr_reg       <= maxr_next;
        worst_reg      <= worst_next;
        nres_reg       <= nres_next;
        nsum_reg       <= nsum_next;
        ncnt_reg       <= ncnt_next;
        known_reg      <= known_next;
        rphase_reg     <= rphase_next;
        ysq_reg        <= ysq_next;
        lhs_reg        <= lhs_next;
        mcand_reg      <= mcand_next;
        mbits_reg      <= mbits_next;
        acc_reg        <= acc_next;
        mcnt_reg       <= mcnt_next;
        obits_reg      <= obits_next;
        olast_reg      <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tsos_pkg::B_IDLE;
            marks_reg  <= '0;
            ov_reg     <= 1'b0;
            above_reg  <= '0;
            below_reg  <= '0;
            nodata_reg <= tsos_pkg::NODATA_RESET;
        end
        else
        begin
            state_reg <= state_next;
            marks_reg <= marks_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tsos_pkg::CFG_ABOVE:  above_reg  <= cfg_data;
                    tsos_pkg::CFG_BELOW:  below_reg  <= cfg_data;
                    tsos_pkg::CFG_NODATA: nodata_reg <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

endmodule

@@ src/time_series_outlier_screen_core.sv @@
// ---------------------------------------------------------------------------
// time_series_outlier_screen_core
// screens one pixel's time series for outliers and restores quiet dates
// ---------------------------------------------------------------------------
//  channel   | direction | transaction
//  s_axis    | in        | one date: sample, day, valid flag; tlast on the final date
//  m_axis    | out       | one result per date after the series ends; tlast on the last
//  cfg       | in        | register write, no read-back
//
//  a date is taken whenever the queue has room; the series end starts the screen in the back part
//  each removal pass walks all n dates, with a residual from the 17-step divider per date
//  and a shift-add noise product per pass
//  results leave at one per cycle while m_tready is high; the two-entry queue lets
//  the front take dates of the next series until it fills while the back is busy
//  reset clears control state and loads the register reset values
// ---------------------------------------------------------------------------
module time_series_outlier_screen_core #(
    parameter int MAX_DATES = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample [15:0], day_number [31:16], valid_in [32], zero fill [39:33]
    input  logic [39:0]                    s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic                           s_tlast,
    // valid_out [0], was_removed [1], screen_ran [2], zero fill [7:3]
    output logic [7:0]                     m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [tsos_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);

    tsos_pkg::entry_t push_data;
    tsos_pkg::entry_t pop_data;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;

    // front: numbers dates and marks the series end
    tsos_front #(
        .MAX_DATES (MAX_DATES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // decouples the front from the screen engine
    tsos_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: store, removal and restore passes, result output register
    tsos_back #(
        .MAX_DATES (MAX_DATES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ src/tsos_checker.sv @@
// ---------------------------------------------------------------------------
// tsos_checker
// port-level checks of the outlier screen
// ---------------------------------------------------------------------------
module tsos_checker (
    input logic       clk,
    input logic       rst_n,
    input logic [7:0] m_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic       m_tlast
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its bits
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // removal only happens when the screen ran
    a_removed_ran: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[2])
        else $error("removed date without screen");

    // a removed date is never valid afterwards
    a_removed_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> !m_tdata[0])
        else $error("removed date reported valid");

endmodule

bind time_series_outlier_screen_core tsos_checker u_tsos_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);
